// ===== design/tbwp_pkg.sv =====
// Package for the tile background and window pixel generator.
// Holds video memory geometry, register indexes and the pipeline stage types.
// No dependencies.
package tbwp_pkg;

   localparam int VRAM_BYTES     = 8192;
   localparam int VRAM_ADDR_BITS = $clog2(VRAM_BYTES);
   localparam int VRAM_WORD_BITS = VRAM_ADDR_BITS - 1;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [2:0] CSR_SCROLL_X        = 3'd0;
   localparam logic [2:0] CSR_SCROLL_Y        = 3'd1;
   localparam logic [2:0] CSR_WINDOW_X        = 3'd2;
   localparam logic [2:0] CSR_WINDOW_Y        = 3'd3;
   localparam logic [2:0] CSR_SHADE_PALETTE   = 3'd4;
   localparam logic [2:0] CSR_DISPLAY_CONTROL = 3'd5;

   // Display control bit positions.
   localparam int DC_BG_ENABLE  = 0;
   localparam int DC_BG_MAP     = 3;
   localparam int DC_TILE_MODE  = 4;
   localparam int DC_WIN_ENABLE = 5;
   localparam int DC_WIN_MAP    = 6;

   // Map area starts at 0x1800 or 0x1C00: top bits 2'b11, then the map select.
   localparam logic [1:0] MAP_AREA_TOP = 2'b11;

   // Control carried alongside the map read.
   typedef struct packed {
      logic       valid;
      logic       drawn;
      logic [2:0] row;
      logic [2:0] bit_sel;
   } tbwp_map_stage_type;

   // Control carried alongside the tile data read.
   typedef struct packed {
      logic       valid;
      logic       drawn;
      logic [2:0] bit_sel;
   } tbwp_tile_stage_type;

endpackage

// ===== design/tbwp_vram.sv =====
// Video memory for the tile background and window pixel generator.
// Two byte banks (even and odd addresses), one write port and two read ports.
// Depends on tbwp_pkg.
module tbwp_vram
   import tbwp_pkg::*;
(
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [VRAM_ADDR_BITS-1:0] wr_addr,
   input  logic [7:0]                wr_data,
   input  logic [VRAM_ADDR_BITS-1:0] map_addr,
   output logic [7:0]                map_byte,
   input  logic [VRAM_WORD_BITS-1:0] tile_addr,
   output logic [15:0]               tile_word
);

   localparam int BANK_DEPTH = VRAM_BYTES / 2;

   logic [7:0] even_mem [BANK_DEPTH];
   logic [7:0] odd_mem  [BANK_DEPTH];

   logic [7:0] even_a_ff;
   logic [7:0] odd_a_ff;
   logic       map_odd_ff;
   logic [7:0] even_b_ff;
   logic [7:0] odd_b_ff;

   // Reads return the old contents when a write hits the same entry at the
   // same edge; the write then always belongs to a later request.
   always_ff @(posedge clock) begin
      if (wr_en && !wr_addr[0]) begin
         even_mem[wr_addr[VRAM_ADDR_BITS-1:1]] <= wr_data;
      end
      even_a_ff <= even_mem[map_addr[VRAM_ADDR_BITS-1:1]];
      even_b_ff <= even_mem[tile_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en && wr_addr[0]) begin
         odd_mem[wr_addr[VRAM_ADDR_BITS-1:1]] <= wr_data;
      end
      odd_a_ff <= odd_mem[map_addr[VRAM_ADDR_BITS-1:1]];
      odd_b_ff <= odd_mem[tile_addr];
   end

   always_ff @(posedge clock) begin
      map_odd_ff <= map_addr[0];
   end

   assign map_byte  = map_odd_ff ? odd_a_ff : even_a_ff;
   assign tile_word = {odd_b_ff, even_b_ff};

endmodule

// ===== design/tile_background_window_pixel.sv =====
// Top level of the tile background and window pixel generator.
// Decodes configuration, runs the three-step map/tile/shade pipeline.
// Depends on tbwp_pkg and tbwp_vram.
//
//   channel   ports                                   handshake
//   request   req_cmd/mem_offset/mem_byte/line/column start high, busy low
//   result    rsp_shade/colour_number/drawn           rsp_strobe, one cycle
//   config    csr_index/csr_wdata                     csr_we, no wait
//
// A new request can be taken every cycle that busy is low. A query's result passes
// through the tile map read, then the tile data read (both from the video memory
// banks), then the shade lookup register.
// A memory write takes effect at its accept edge and returns no result.
// Busy is high only during reset; the result side never stalls.
module tile_background_window_pixel
   import tbwp_pkg::*;
#(
   parameter int SCREEN_WIDTH = 160
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_cmd,
   input  logic [VRAM_ADDR_BITS-1:0] req_mem_offset,
   input  logic [7:0]                req_mem_byte,
   input  logic [7:0]                req_screen_line,
   input  logic [7:0]                req_screen_column,
   output logic                      rsp_strobe,
   output logic [1:0]                rsp_shade,
   output logic [1:0]                rsp_colour_number,
   output logic                      rsp_drawn,
   input  logic                      csr_we,
   input  logic [2:0]                csr_index,
   input  logic [7:0]                csr_wdata
);

   logic [7:0] scroll_x_ff;
   logic [7:0] scroll_y_ff;
   logic [7:0] window_x_ff;
   logic [7:0] window_y_ff;
   logic [7:0] palette_ff;
   logic [7:0] control_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scroll_x_ff <= '0;
         scroll_y_ff <= '0;
         window_x_ff <= '0;
         window_y_ff <= '0;
         palette_ff  <= '0;
         control_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SCROLL_X:        scroll_x_ff <= csr_wdata;
            CSR_SCROLL_Y:        scroll_y_ff <= csr_wdata;
            CSR_WINDOW_X:        window_x_ff <= csr_wdata;
            CSR_WINDOW_Y:        window_y_ff <= csr_wdata;
            CSR_SHADE_PALETTE:   palette_ff  <= csr_wdata;
            CSR_DISPLAY_CONTROL: control_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = reset;

   logic accept;
   logic query_acc;
   logic write_acc;
   assign accept    = start && !busy;
   assign query_acc = accept && (req_cmd == CMD_QUERY);
   assign write_acc = accept && (req_cmd == CMD_WRITE);

   // Layer selection and map address for the accepted query.
   logic                      on_line;
   logic                      use_window;
   logic [7:0]                x_coord;
   logic [7:0]                y_coord;
   logic                      map_sel;
   logic [VRAM_ADDR_BITS-1:0] map_addr;
   tbwp_map_stage_type        map_stage_in;
   tbwp_map_stage_type        map_stage_ff;

   always_comb begin
      on_line    = {1'b0, req_screen_column} < 9'(SCREEN_WIDTH);
      use_window = control_ff[DC_WIN_ENABLE] && (req_screen_line >= window_y_ff)
                   && (req_screen_column >= window_x_ff);
      if (use_window) begin
         x_coord = req_screen_column - window_x_ff;
         y_coord = req_screen_line - window_y_ff;
         map_sel = control_ff[DC_WIN_MAP];
      end else begin
         x_coord = req_screen_column + scroll_x_ff;
         y_coord = req_screen_line + scroll_y_ff;
         map_sel = control_ff[DC_BG_MAP];
      end
      map_addr = {MAP_AREA_TOP, map_sel, y_coord[7:3], x_coord[7:3]};
      map_stage_in.valid   = query_acc;
      map_stage_in.drawn   = on_line && (use_window || control_ff[DC_BG_ENABLE]);
      map_stage_in.row     = y_coord[2:0];
      map_stage_in.bit_sel = ~x_coord[2:0];
   end

   // Tile data address from the tile index just read.
   logic [7:0]                tile_index;
   logic                      tile_hi;
   logic [VRAM_WORD_BITS-1:0] tile_addr;
   tbwp_tile_stage_type       tile_stage_in;
   tbwp_tile_stage_type       tile_stage_ff;

   // In signed mode 0x1000 + s*16 equals the index with its top bit inverted
   // placed above the index itself.
   always_comb begin
      tile_hi   = control_ff[DC_TILE_MODE] ? 1'b0 : ~tile_index[7];
      tile_addr = {tile_hi, tile_index, map_stage_ff.row};
      tile_stage_in.valid   = map_stage_ff.valid;
      tile_stage_in.drawn   = map_stage_ff.drawn;
      tile_stage_in.bit_sel = map_stage_ff.bit_sel;
   end

   logic [15:0] tile_word;

   tbwp_vram u_vram (
      .clock     (clock),
      .wr_en     (write_acc),
      .wr_addr   (req_mem_offset),
      .wr_data   (req_mem_byte),
      .map_addr  (map_addr),
      .map_byte  (tile_index),
      .tile_addr (tile_addr),
      .tile_word (tile_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         map_stage_ff.valid  <= 1'b0;
         tile_stage_ff.valid <= 1'b0;
      end else begin
         map_stage_ff.valid  <= map_stage_in.valid;
         tile_stage_ff.valid <= tile_stage_in.valid;
      end
      map_stage_ff.drawn    <= map_stage_in.drawn;
      map_stage_ff.row      <= map_stage_in.row;
      map_stage_ff.bit_sel  <= map_stage_in.bit_sel;
      tile_stage_ff.drawn   <= tile_stage_in.drawn;
      tile_stage_ff.bit_sel <= tile_stage_in.bit_sel;
   end

   // Colour from the two bit planes, then the palette.
   logic [1:0] colour_in;
   logic [1:0] shade_in;
   logic       strobe_ff;
   logic [1:0] shade_ff;
   logic [1:0] colour_ff;
   logic       drawn_ff;

   always_comb begin
      colour_in = 2'b00;
      shade_in  = 2'b00;
      if (tile_stage_ff.drawn) begin
         colour_in = {tile_word[4'd8 + {1'b0, tile_stage_ff.bit_sel}],
                      tile_word[{1'b0, tile_stage_ff.bit_sel}]};
         shade_in  = palette_ff[{colour_in, 1'b1} -: 2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= tile_stage_ff.valid;
      end
      shade_ff  <= shade_in;
      colour_ff <= colour_in;
      drawn_ff  <= tile_stage_ff.drawn;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_shade         = shade_ff;
   assign rsp_colour_number = colour_ff;
   assign rsp_drawn         = drawn_ff;

   // Every query gives exactly one result strobe, after the map, tile and shade registers; writes give none.
   a_result_per_query: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe == $past(query_acc, 3))
      else $error("result strobe does not match an accepted query");

   // A pixel that no layer drew carries zero colour and shade.
   a_undrawn_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_drawn) |-> (rsp_shade == 2'b00 && rsp_colour_number == 2'b00))
      else $error("undrawn pixel with nonzero colour or shade");

   // A pixel that lies off the line is never drawn.
   a_off_line: assert property (@(posedge clock) disable iff (reset)
      (query_acc && !on_line) |-> ##3 !rsp_drawn)
      else $error("pixel beyond the line width reported as drawn");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for tile_background_window_pixel.
// Fills video memory, then runs directed and random pixel traffic against an inline predictor.
// Depends on tbwp_pkg and the design sources only.
`timescale 1ns / 100ps

module testbench;
   import tbwp_pkg::*;

   localparam int SCREEN_WIDTH = 160;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 100;
   localparam int REPORT_LINES = 20;

   localparam logic [7:0] BG_ON          = 8'h01 << DC_BG_ENABLE;
   localparam logic [7:0] BG_MAP_HIGH    = 8'h01 << DC_BG_MAP;
   localparam logic [7:0] TILES_UNSIGNED = 8'h01 << DC_TILE_MODE;
   localparam logic [7:0] WIN_ON         = 8'h01 << DC_WIN_ENABLE;
   localparam logic [7:0] WIN_MAP_HIGH   = 8'h01 << DC_WIN_MAP;

   typedef struct packed {
      logic [1:0] shade;
      logic [1:0] colour;
      logic       drawn;
   } pixel_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_cmd = CMD_WRITE;
   logic [VRAM_ADDR_BITS-1:0] req_mem_offset = '0;
   logic [7:0]                req_mem_byte = '0;
   logic [7:0]                req_screen_line = '0;
   logic [7:0]                req_screen_column = '0;
   logic                      rsp_strobe;
   logic [1:0]                rsp_shade;
   logic [1:0]                rsp_colour_number;
   logic                      rsp_drawn;
   logic                      csr_we = 1'b0;
   logic [2:0]                csr_index = CSR_SCROLL_X;
   logic [7:0]                csr_wdata = '0;

   // Predictor state: a copy of video memory and of the registers.
   logic [7:0]                vram_image [VRAM_BYTES];
   logic [7:0]                bg_scroll_x, bg_scroll_y, win_col, win_line, palette, lcd_ctrl;
   logic [VRAM_ADDR_BITS-1:0] touched [3];
   pixel_type                 pending_pixels [$];

   int  mismatch_count = 0;
   int  query_count = 0;
   int  write_count = 0;
   int  setting_count = 0;
   int  cycle_count = 0;
   bit  steady_phase = 1'b0;

   tile_background_window_pixel #(.SCREEN_WIDTH(SCREEN_WIDTH)) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run timed out after %0d cycles with %0d results outstanding.",
                  cycle_count, pending_pixels.size());
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < REPORT_LINES)
         $display("%0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   // Colour of one layer pixel; also records the three bytes it reads.
   function automatic logic [1:0] layer_colour(input logic high_map, input logic [7:0] y,
                                               input logic [7:0] x);
      logic [VRAM_ADDR_BITS-1:0] map_addr;
      logic [VRAM_ADDR_BITS-1:0] data_addr;
      logic [7:0]                tile;
      int                        bit_pos;
      map_addr = {2'b11, high_map, y[7:3], x[7:3]};
      tile = vram_image[map_addr];
      if (lcd_ctrl[DC_TILE_MODE])
         data_addr = {1'b0, tile, y[2:0], 1'b0};
      else
         // Signed tile index around 0x1000, kept modulo the memory size.
         data_addr = 13'h1000 + {tile[7], tile, 4'b0000} + {9'b0, y[2:0], 1'b0};
      bit_pos = 7 - x[2:0];
      touched[0] = map_addr;
      touched[1] = data_addr;
      touched[2] = data_addr + 13'd1;
      return {vram_image[touched[2]][bit_pos], vram_image[data_addr][bit_pos]};
   endfunction

   function automatic pixel_type predict_pixel(input logic [7:0] line, input logic [7:0] column);
      pixel_type px;
      logic [1:0] colour;
      logic hit;
      px = '0;
      colour = 2'd0;
      hit = 1'b0;
      if (column < SCREEN_WIDTH) begin
         if (lcd_ctrl[DC_BG_ENABLE]) begin
            colour = layer_colour(lcd_ctrl[DC_BG_MAP], 8'(line + bg_scroll_y),
                                  8'(column + bg_scroll_x));
            hit = 1'b1;
         end
         if (lcd_ctrl[DC_WIN_ENABLE] && line >= win_line && column >= win_col) begin
            colour = layer_colour(lcd_ctrl[DC_WIN_MAP], 8'(line - win_line),
                                  8'(column - win_col));
            hit = 1'b1;
         end
      end
      if (hit) begin
         px.shade = palette[2*colour +: 2];
         px.colour = colour;
         px.drawn = 1'b1;
      end
      return px;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_phase || r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] random_line();
      return ($urandom_range(0, 4) == 0) ? 8'($urandom_range(144, 255))
                                         : 8'($urandom_range(0, 143));
   endfunction

   function automatic logic [7:0] random_column();
      return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(SCREEN_WIDTH, 255))
                                         : 8'($urandom_range(0, SCREEN_WIDTH - 1));
   endfunction

   // Drives one request and holds it until the edge that accepts it.
   task automatic send_request(input logic cmd, input logic [VRAM_ADDR_BITS-1:0] offset,
                               input logic [7:0] data, input logic [7:0] line,
                               input logic [7:0] column, input int gap);
      start <= 1'b1;
      req_cmd <= cmd;
      req_mem_offset <= offset;
      req_mem_byte <= data;
      req_screen_line <= line;
      req_screen_column <= column;
      do @(posedge clock); while (busy);
      if (cmd == CMD_WRITE) begin
         vram_image[offset] = data;
         write_count++;
      end else begin
         pending_pixels.push_back(predict_pixel(line, column));
         query_count++;
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_write(input logic [VRAM_ADDR_BITS-1:0] offset, input logic [7:0] data,
                             input int gap);
      send_request(CMD_WRITE, offset, data, 8'($urandom), 8'($urandom), gap);
   endtask

   task automatic send_query(input logic [7:0] line, input logic [7:0] column, input int gap);
      send_request(CMD_QUERY, 13'($urandom), 8'($urandom), line, column, gap);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [7:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Registers change only once the pipeline has drained.
   task automatic configure(input logic [7:0] sx, input logic [7:0] sy, input logic [7:0] wx,
                            input logic [7:0] wy, input logic [7:0] pal, input logic [7:0] dc);
      start <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      write_register(CSR_SCROLL_X, sx);
      write_register(CSR_SCROLL_Y, sy);
      write_register(CSR_WINDOW_X, wx);
      write_register(CSR_WINDOW_Y, wy);
      write_register(CSR_SHADE_PALETTE, pal);
      write_register(CSR_DISPLAY_CONTROL, dc);
      csr_we <= 1'b0;
      bg_scroll_x = sx;
      bg_scroll_y = sy;
      win_col = wx;
      win_line = wy;
      palette = pal;
      lcd_ctrl = dc;
      setting_count++;
   endtask

   // Every byte gets written once so no query ever reads undefined memory.
   task automatic fill_video_memory();
      for (int a = 0; a < VRAM_BYTES; a++)
         send_write(13'(a), 8'($urandom), 0);
   endtask

   task automatic test_memory_extremes();
      configure(8'd96, 8'd0, 8'd0, 8'd0, 8'hE4, BG_ON | BG_MAP_HIGH | TILES_UNSIGNED);
      send_write(13'h0000, 8'h00, 0);
      send_write(13'h1FFF, 8'hFF, 1);
      // Scrolled to the last map entry, which now selects tile 255.
      send_query(8'd255, 8'd159, 0);
   endtask

   task automatic test_no_layer();
      configure(8'd0, 8'd0, 8'd0, 8'd0, 8'hFF, 8'h00);
      send_query(8'd0, 8'd0, 0);
      send_query(8'd143, 8'd159, 0);
   endtask

   task automatic test_off_line_columns();
      configure(8'd0, 8'd0, 8'd0, 8'd0, 8'h1B, BG_ON | WIN_ON | TILES_UNSIGNED);
      send_query(8'd10, 8'd160, 0);
      send_query(8'd10, 8'd255, 2);
      send_query(8'd10, 8'd159, 0);
   endtask

   task automatic test_lines_below_screen();
      configure(8'd0, 8'h80, 8'd0, 8'd0, 8'h6C, BG_ON);
      send_query(8'd200, 8'd5, 0);
      send_query(8'd255, 8'd0, 0);
   endtask

   task automatic test_window_only();
      configure(8'd0, 8'd0, 8'd8, 8'd16, 8'hE4, WIN_ON | WIN_MAP_HIGH | TILES_UNSIGNED);
      send_query(8'd20, 8'd10, 0);
      send_query(8'd0, 8'd0, 0);
      send_query(8'd16, 8'd8, 1);
      send_query(8'd15, 8'd8, 0);
   endtask

   task automatic test_tile_index_modes();
      configure(8'd0, 8'd0, 8'd0, 8'd0, 8'hE4, BG_ON);
      send_write(13'h1800, 8'h80, 0);
      send_query(8'd0, 8'd0, 0);
      send_write(13'h1800, 8'h7F, 0);
      send_query(8'd1, 8'd3, 0);
      configure(8'd0, 8'd0, 8'd0, 8'd0, 8'hE4, BG_ON | TILES_UNSIGNED);
      send_query(8'd2, 8'd6, 0);
   endtask

   // Mostly queries, many right behind a write to a byte they read, plus stray writes.
   task automatic test_random_traffic();
      int sent;
      int r;
      logic [7:0] line, column;
      for (int phase = 0; phase < 9; phase++) begin
         if (phase == 0)
            configure(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
         else if (phase == 1)
            configure(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
         else
            configure(8'($urandom), 8'($urandom), 8'($urandom_range(0, 167)),
                      8'($urandom_range(0, 150)), 8'($urandom), 8'($urandom));
         steady_phase = (phase == 2) || ($urandom_range(0, 4) == 0);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            line = random_line();
            column = random_column();
            if (r < 55) begin
               send_query(line, column, pick_gap());
               sent += 1;
            end else if (r < 80) begin
               void'(predict_pixel(line, column));
               send_write(touched[$urandom_range(0, 2)], 8'($urandom),
                          $urandom_range(0, 1) ? 0 : pick_gap());
               send_query(line, column, pick_gap());
               sent += 2;
            end else begin
               send_write(13'($urandom), 8'($urandom), pick_gap());
               sent += 1;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_strobe) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("result arrived with no query outstanding");
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_shade !== want.shade)
               report_mismatch($sformatf("shade got %0d expected %0d", rsp_shade, want.shade));
            if (rsp_colour_number !== want.colour)
               report_mismatch($sformatf("colour number got %0d expected %0d",
                                         rsp_colour_number, want.colour));
            if (rsp_drawn !== want.drawn)
               report_mismatch($sformatf("drawn got %0d expected %0d", rsp_drawn, want.drawn));
         end
      end
   end

   initial begin
      bg_scroll_x = '0;
      bg_scroll_y = '0;
      win_col = '0;
      win_line = '0;
      palette = '0;
      lcd_ctrl = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      fill_video_memory();
      test_memory_extremes();
      test_no_layer();
      test_off_line_columns();
      test_lines_below_screen();
      test_window_only();
      test_tile_index_modes();
      test_random_traffic();
      start <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Checked %0d pixel queries and %0d video memory writes", query_count, write_count);
      $display("across %0d register settings; %0d field errors.", setting_count, mismatch_count);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
